// File: rtl/vpu_pkg.sv
// vpu_pkg: shared types and constants for the vector projection unit.
// Used by vpu_div and vector_projection_unit; depends on nothing else.

package vpu_pkg;

    // Item and result payloads
    typedef struct packed {
        logic signed [31:0] a_elem;
        logic signed [31:0] b_elem;
        logic               last;
    } vpu_item_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic [3:0]         elem_index;
        logic               last_out;
        logic [1:0]         status;
    } vpu_result_t;

    // Status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_ZERO_B   = 2'd1;
    localparam logic [1:0] STAT_OVERFLOW = 2'd2;

    // Configuration register map (index = paddr[2])
    localparam int unsigned  PADDR_W  = 3;
    localparam logic         REG_MODE = 1'b0;

    // Q16.16 scale division: 64-bit magnitude widened by 16 fraction bits
    localparam int unsigned FRAC_BITS = 16;
    localparam int unsigned DVD_W     = 64 + FRAC_BITS;
    localparam int unsigned DIV_CNT_W = $clog2(DVD_W);

endpackage

// File: rtl/vpu_div.sv
// vpu_div: restoring divider forming the Q16.16 scale num*2^16/den,
// truncated toward zero and saturated to 32 bits. Depends on vpu_pkg.

module vpu_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [63:0]  num,
    input  logic [63:0]         den,
    output logic                done,
    output logic signed [31:0]  scale
);
    import vpu_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0]     dvd_reg;
    logic [63:0]          den_reg;
    logic [63:0]          rem_reg;
    logic [31:0]          quo_reg;
    logic                 high_reg;
    logic                 neg_reg;

    logic [64:0] rem_shift;
    logic        fits;
    logic [63:0] rem_next;
    logic [63:0] mag;

    assign mag       = num[63] ? 64'(-num) : 64'(num);
    assign rem_shift = {rem_reg, dvd_reg[DVD_W-1]};
    assign fits      = rem_shift >= {1'b0, den_reg};
    assign rem_next  = fits ? 64'(rem_shift - {1'b0, den_reg}) : rem_shift[63:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg  <= {mag, {FRAC_BITS{1'b0}}};
            den_reg  <= den;
            rem_reg  <= '0;
            quo_reg  <= '0;
            high_reg <= 1'b0;
            neg_reg  <= num[63];
        end
        else if (busy_reg)
        begin
            dvd_reg  <= {dvd_reg[DVD_W-2:0], 1'b0};
            rem_reg  <= rem_next;
            // any quotient bit pushed past 32 bits forces saturation
            quo_reg  <= {quo_reg[30:0], fits};
            high_reg <= high_reg | quo_reg[31];
        end
    end

    always_comb
    begin
        if (neg_reg)
        begin
            if (high_reg || (quo_reg > 32'h8000_0000))
                scale = 32'sh8000_0000;
            else
                scale = $signed(-quo_reg);
        end
        else
        begin
            if (high_reg || quo_reg[31])
                scale = 32'sh7FFF_FFFF;
            else
                scale = $signed(quo_reg);
        end
    end

    assign done = done_reg;

endmodule

// File: rtl/vector_projection_unit.sv
// vector_projection_unit: projection / rejection of vector a onto vector b.
// Depends on vpu_pkg and vpu_div.
//
// Usage:
//   Element pairs (a_elem, b_elem, last) enter on the item channel
//   (item_valid/item_ready), one transfer per cycle while loading. Pairs
//   go into two element buffers (registered read) and their
//   products are summed into 64-bit saturating dot_ab and dot_bb.
//   The pair marked last ends the vector: item_ready drops, the scale
//   dot_ab/dot_bb is formed by a one-bit-per-cycle divider (skipped
//   when b is zero), then one result per buffered element leaves
//   on the result channel (result_valid/result_ready).
//   Elements are handled one at a time, each passing in turn through the
//   buffer read, the shared multiplier and the output register. Pairs
//   beyond MAX_DIM are dropped and reported as status 2; a zero b takes
//   priority and is reported as status 1. A stalled receiver holds the
//   result register and freezes the emission pass; nothing is lost. Reset
//   clears the sums, the fill count and the mode register (projection);
//   buffer contents are left as they are. mode_select sits at APB address
//   0 and must be written only while idle; the block does not enforce it.

module vector_projection_unit #(
    parameter int unsigned MAX_DIM = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // item channel
    input  logic                              item_valid,
    output logic                              item_ready,
    input  vpu_pkg::vpu_item_t                item,
    // result channel
    output logic                              result_valid,
    input  logic                              result_ready,
    output vpu_pkg::vpu_result_t              result,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [vpu_pkg::PADDR_W-1:0]       paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import vpu_pkg::*;

    localparam int unsigned IW = $clog2(MAX_DIM);
    localparam int unsigned CW = $clog2(MAX_DIM + 1);

    typedef enum logic [6:0] {
        S_LOAD   = 7'b0000001,
        S_SETTLE = 7'b0000010,
        S_CHECK  = 7'b0000100,
        S_DIV    = 7'b0001000,
        S_RD     = 7'b0010000,
        S_MUL    = 7'b0100000,
        S_OUT    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic               mode_reg;
    logic [CW-1:0]      fill_reg;
    logic [IW-1:0]      idx_reg;
    logic               ovf_reg;
    logic [1:0]         status_reg;
    logic signed [31:0] scale_reg;
    logic signed [63:0] dot_ab_reg;
    logic signed [63:0] dot_bb_reg;
    logic signed [63:0] pab_reg;
    logic signed [63:0] pbb_reg;
    logic               pv_reg;
    logic               result_valid_reg;
    vpu_result_t        result_reg;

    // element buffers
    logic signed [31:0] a_mem [MAX_DIM];
    logic signed [31:0] b_mem [MAX_DIM];
    logic signed [31:0] a_rd_reg;
    logic signed [31:0] b_rd_reg;

    logic               take;
    logic               keep;
    logic               cfg_wr;
    logic               out_free;
    logic               is_final;
    logic               div_start;
    logic               div_done;
    logic signed [31:0] div_scale;
    logic signed [31:0] mul_x;
    logic signed [31:0] mul_y;
    logic signed [63:0] mul_p;
    logic signed [63:0] sq_p;
    logic signed [47:0] proj;
    logic signed [48:0] perp;
    logic signed [31:0] value_c;

    function automatic logic signed [63:0] sat_add64(
        input logic signed [63:0] x,
        input logic signed [63:0] y
    );
        logic signed [64:0] s;
        begin
            s = {x[63], x} + {y[63], y};
            if (s[64] != s[63])
                sat_add64 = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            else
                sat_add64 = s[63:0];
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [48:0] x);
        begin
            if (x > 49'sd2147483647)
                sat32 = 32'sh7FFF_FFFF;
            else if (x < -49'sd2147483648)
                sat32 = 32'sh8000_0000;
            else
                sat32 = x[31:0];
        end
    endfunction

    assign item_ready = (state_reg == S_LOAD);
    assign take       = item_valid && item_ready;
    assign keep       = take && (fill_reg < CW'(MAX_DIM));
    assign cfg_wr     = psel && penable && pwrite && pready;
    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == REG_MODE) ? {31'd0, mode_reg} : 32'd0;
    assign out_free   = !result_valid_reg || result_ready;
    assign is_final   = (CW'(idx_reg) + CW'(1)) == fill_reg;
    assign div_start  = (state_reg == S_CHECK) && (dot_bb_reg != 64'sd0);

    // one multiplier shared by loading (a*b) and emission (scale*b)
    assign mul_x = (state_reg == S_LOAD) ? item.a_elem : scale_reg;
    assign mul_y = (state_reg == S_LOAD) ? item.b_elem : b_rd_reg;
    assign mul_p = mul_x * mul_y;
    assign sq_p  = item.b_elem * item.b_elem;

    // floor(scale*b / 2^16), then optional a - proj
    assign proj = pab_reg[63:FRAC_BITS];
    assign perp = 49'(a_rd_reg) - 49'(proj);

    always_comb
    begin
        if (status_reg == STAT_ZERO_B)
            value_c = '0;
        else if (mode_reg)
            value_c = sat32(perp);
        else
            value_c = sat32(49'(proj));
    end

    vpu_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (dot_ab_reg),
        .den   (64'(dot_bb_reg)),
        .done  (div_done),
        .scale (div_scale)
    );

    always_ff @(posedge clk)
    begin
        if (keep)
        begin
            a_mem[fill_reg[IW-1:0]] <= item.a_elem;
            b_mem[fill_reg[IW-1:0]] <= item.b_elem;
        end
        a_rd_reg <= a_mem[idx_reg];
        b_rd_reg <= b_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        pab_reg <= mul_p;
        pbb_reg <= sq_p;
        if (div_done)
            scale_reg <= div_scale;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                if (take && item.last)
                    state_next = S_SETTLE;
            end
            S_SETTLE: state_next = S_CHECK;
            S_CHECK:  state_next = div_start ? S_DIV : S_RD;
            S_DIV:
            begin
                if (div_done)
                    state_next = S_RD;
            end
            S_RD:     state_next = S_MUL;
            S_MUL:    state_next = S_OUT;
            S_OUT:
            begin
                if (out_free)
                    state_next = is_final ? S_LOAD : S_RD;
            end
            default:  state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_LOAD;
            mode_reg         <= 1'b0;
            fill_reg         <= '0;
            idx_reg          <= '0;
            ovf_reg          <= 1'b0;
            status_reg       <= STAT_OK;
            dot_ab_reg       <= '0;
            dot_bb_reg       <= '0;
            pv_reg           <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pv_reg    <= keep;

            if (cfg_wr && (paddr[2] == REG_MODE))
                mode_reg <= pwdata[0];

            if (keep)
                fill_reg <= fill_reg + 1'b1;
            else if (take)
                ovf_reg <= 1'b1;

            if (pv_reg)
            begin
                dot_ab_reg <= sat_add64(dot_ab_reg, pab_reg);
                dot_bb_reg <= sat_add64(dot_bb_reg, pbb_reg);
            end

            if (state_reg == S_CHECK)
            begin
                idx_reg <= '0;
                if (dot_bb_reg == 64'sd0)
                    status_reg <= STAT_ZERO_B;
                else if (ovf_reg)
                    status_reg <= STAT_OVERFLOW;
                else
                    status_reg <= STAT_OK;
            end

            if ((state_reg == S_OUT) && out_free)
                result_valid_reg <= 1'b1;
            else if (result_valid_reg && result_ready)
                result_valid_reg <= 1'b0;

            if ((state_reg == S_OUT) && out_free)
            begin
                if (is_final)
                begin
                    // vector done: clear for the next one
                    fill_reg   <= '0;
                    ovf_reg    <= 1'b0;
                    dot_ab_reg <= '0;
                    dot_bb_reg <= '0;
                end
                else
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_OUT) && out_free)
        begin
            result_reg.value      <= value_c;
            result_reg.elem_index <= 4'(idx_reg);
            result_reg.last_out   <= is_final;
            result_reg.status     <= status_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// File: tb/vector_projection_unit_tb.sv
`timescale 1ns / 100ps
// Testbench for vector_projection_unit: a scoreboard class predicts every result element.
// Plain tasks drive the item channel and the APB port; a loop drives result_ready.
// Depends on vpu_pkg and the vector_projection_unit RTL.

module vector_projection_unit_tb;

    import vpu_pkg::*;

    localparam int          DIM         = 16;
    localparam int          VEC_ITEMS   = 480;
    localparam int          PHASES      = 6;
    localparam int          CYCLE_LIMIT = 800000;
    localparam int          DRAIN_WAIT  = 100;
    localparam logic        MODE_PROJ   = 1'b0;
    localparam logic        MODE_PERP   = 1'b1;
    localparam int          ELEM_FULL   = 0;
    localparam int          ELEM_SMALL  = 1;
    localparam int          ELEM_EDGE   = 2;
    localparam int          ELEM_MIXED  = 3;
    localparam logic [31:0] Q_MIN       = 32'h8000_0000;
    localparam logic [31:0] Q_MAX       = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_ONE       = 32'h0001_0000;
    localparam logic [PADDR_W-1:0] MODE_ADDR = {REG_MODE, 2'b00};

    class projection_checker;
        logic signed [31:0] a_buf [DIM];
        logic signed [31:0] b_buf [DIM];
        longint             dot_ab;
        longint             dot_bb;
        int unsigned        fill_count;
        bit                 dropped;
        logic               mode;
        vpu_result_t        expected_elems [$];
        int unsigned        mismatch_count;

        function new();
            mode = MODE_PROJ;
            mismatch_count = 0;
            clear_sums();
        endfunction

        function void clear_sums();
            dot_ab = 0;
            dot_bb = 0;
            fill_count = 0;
            dropped = 0;
        endfunction

        function longint add_sat64(longint acc, longint p);
            logic signed [64:0] s;
            s = {acc[63], acc} + {p[63], p};
            if (s[64] != s[63])
                return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            return s[63:0];
        endfunction

        function logic signed [31:0] clamp32(longint x);
            if (x > 64'sd2147483647)
                return Q_MAX;
            if (x < -64'sd2147483648)
                return Q_MIN;
            return x[31:0];
        endfunction

        // Q16.16 quotient, truncated toward zero; den is positive
        function longint scale_of(longint num, longint den);
            logic signed [79:0] n;
            logic signed [79:0] d;
            logic signed [79:0] q;
            n = {num, 16'd0};
            d = {16'd0, den};
            q = n / d;
            if (q > 80'sd2147483647)
                return 64'sd2147483647;
            if (q < -80'sd2147483648)
                return -64'sd2147483648;
            return longint'(q[63:0]);
        endfunction

        task report_mismatch(input string msg);
            $display("MISMATCH: %s", msg);
            mismatch_count++;
        endtask

        task take_pair(input vpu_item_t it);
            logic [1:0]  st;
            longint      scale;
            longint      p;
            longint      v;
            vpu_result_t r;
            if (fill_count < DIM) begin
                a_buf[fill_count] = it.a_elem;
                b_buf[fill_count] = it.b_elem;
                dot_ab = add_sat64(dot_ab, longint'(it.a_elem) * longint'(it.b_elem));
                dot_bb = add_sat64(dot_bb, longint'(it.b_elem) * longint'(it.b_elem));
                fill_count++;
            end
            else begin
                dropped = 1;
            end
            if (!it.last)
                return;
            if (dot_bb == 0)
                st = STAT_ZERO_B;
            else if (dropped)
                st = STAT_OVERFLOW;
            else
                st = STAT_OK;
            scale = (st == STAT_ZERO_B) ? 0 : scale_of(dot_ab, dot_bb);
            for (int i = 0; i < fill_count; i++) begin
                v = 0;
                if (st != STAT_ZERO_B) begin
                    p = (scale * longint'(b_buf[i])) >>> 16;
                    v = (mode == MODE_PERP) ? longint'(a_buf[i]) - p : p;
                end
                r.value      = clamp32(v);
                r.elem_index = 4'(i);
                r.last_out   = (i + 1 == fill_count);
                r.status     = st;
                expected_elems.push_back(r);
            end
            clear_sums();
        endtask

        task match_elem(input vpu_result_t got);
            vpu_result_t want;
            if (expected_elems.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected: value %0d index %0d",
                                          got.value, got.elem_index));
                return;
            end
            want = expected_elems.pop_front();
            if (got.value !== want.value)
                report_mismatch($sformatf("index %0d value got %0d exp %0d",
                                          want.elem_index, got.value, want.value));
            if (got.elem_index !== want.elem_index)
                report_mismatch($sformatf("elem_index got %0d exp %0d",
                                          got.elem_index, want.elem_index));
            if (got.last_out !== want.last_out)
                report_mismatch($sformatf("index %0d last_out got %0b exp %0b",
                                          want.elem_index, got.last_out, want.last_out));
            if (got.status !== want.status)
                report_mismatch($sformatf("index %0d status got %0d exp %0d",
                                          want.elem_index, got.status, want.status));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_ready;
    vpu_item_t   item;
    logic        result_valid;
    logic        result_ready;
    vpu_result_t result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    projection_checker sb;
    bit          send_idle;
    bit          recv_idle;
    int          items_sent;
    int          cycle_count;

    vector_projection_unit #(
        .MAX_DIM(DIM)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("vector_projection_unit_tb failed");
            $finish;
        end
    end

    function automatic logic [31:0] pick_elem(input int kind);
        case (kind)
            ELEM_SMALL: return 32'(int'($urandom_range(0, 2097151)) - 1048576);
            ELEM_EDGE:
            begin
                case ($urandom_range(0, 5))
                    0: return Q_MIN;
                    1: return Q_MAX;
                    2: return 32'd0;
                    3: return 32'd1;
                    4: return 32'hFFFF_FFFF;
                    default: return Q_ONE;
                endcase
            end
            ELEM_MIXED: return pick_elem($urandom_range(ELEM_FULL, ELEM_EDGE));
            default: return $urandom();
        endcase
    endfunction

    task automatic send_pair(input logic [31:0] a, input logic [31:0] b, input logic last);
        int gap;
        gap = send_idle ? $urandom_range(0, 9) : 0;
        @(negedge clk);
        repeat (gap)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid  <= 1'b1;
        item.a_elem <= a;
        item.b_elem <= b;
        item.last   <= last;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        sb.take_pair('{a_elem: a, b_elem: b, last: last});
        items_sent++;
    endtask

    task automatic end_burst();
        @(negedge clk);
        item_valid <= 1'b0;
    endtask

    task automatic send_vector(input int len, input int style, input bit zero_b);
        logic [31:0] b;
        for (int i = 0; i < len; i++)
        begin
            b = zero_b ? 32'd0 : pick_elem(style);
            send_pair(pick_elem(style), b, i == len - 1);
        end
    endtask

    // hold until the last vector has drained, then give the pipeline time to settle
    task automatic wait_drain();
        while (sb.expected_elems.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_mode(input logic m);
        logic [31:0] word;
        word = $urandom();
        word[0] = m;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MODE_ADDR;
        pwdata  <= word;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.mode = m;
        // read back through a second transfer
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[0] !== m)
            sb.report_mismatch($sformatf("mode_select read %0b exp %0b", prdata[0], m));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // result side: stall for a drawn number of cycles, then take one transfer
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = recv_idle ? $urandom_range(0, 9) : 0;
            repeat (stall)
            begin
                result_ready <= 1'b0;
                @(negedge clk);
            end
            result_ready <= 1'b1;
            @(posedge clk);
            while (!result_valid)
                @(posedge clk);
            sb.match_elem(result);
            @(negedge clk);
        end
    end

    initial
    begin
        int phase_items;
        int len;
        sb = new();
        send_idle    = 0;
        recv_idle    = 0;
        items_sent   = 0;
        cycle_count  = 0;
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        result_ready = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        write_mode(MODE_PROJ);
        send_idle = 1;
        recv_idle = 1;
        // extremes: saturated scale, saturated dot_bb, unit values
        send_pair(Q_MAX, Q_MIN, 1'b1);
        send_pair(Q_MIN, Q_MIN, 1'b0);
        send_pair(Q_MAX, Q_MIN, 1'b1);
        send_pair(32'd1, 32'd1, 1'b1);
        send_pair(Q_MAX, 32'd1, 1'b1);
        // zero b vector
        send_pair(32'h1234_5678, 32'd0, 1'b0);
        send_pair(Q_MIN, 32'd0, 1'b0);
        send_pair(Q_MAX, 32'd0, 1'b1);
        // overflow on a zero b: the dropped pair must not enter the sums
        for (int i = 0; i < DIM; i++)
            send_pair(32'(i) * Q_ONE, 32'd0, 1'b0);
        send_pair(Q_ONE, Q_MAX, 1'b1);
        end_burst();

        items_sent = 0;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_drain();
            write_mode((ph % 2) ? MODE_PERP : MODE_PROJ);
            send_idle = (ph == 0) ? 0 : ($urandom_range(0, 3) != 0);
            recv_idle = (ph == 0) ? 0 : ($urandom_range(0, 3) != 0);
            phase_items = items_sent;
            while (items_sent - phase_items < VEC_ITEMS / PHASES)
            begin
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(DIM + 1, DIM + 4)
                                                  : $urandom_range(1, DIM);
                send_vector(len, $urandom_range(ELEM_FULL, ELEM_MIXED),
                            $urandom_range(0, 7) == 0);
            end
            end_burst();
        end

        while (sb.expected_elems.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.mismatch_count == 0)
            $display("vector_projection_unit_tb passed");
        else
            $display("vector_projection_unit_tb failed");
        $finish;
    end

endmodule
